[rtl/lru_handle_cache_assert.svh]
// Assertion macros for the handle cache.
`ifndef LRU_HANDLE_CACHE_ASSERT_SVH
`define LRU_HANDLE_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define LHC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("handle cache check failed");
`define LHC_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("handle cache check failed");
`else
`define LHC_ASSERT(lbl, clk, rst, prop)
`define LHC_ASSERT_NR(lbl, clk, prop)
`endif
`endif

[rtl/lhc_pkg.sv]
package lhc_pkg;

   localparam int ENTRIES    = 16;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int KEY_WORDS  = 4;
   localparam int WORD_BITS  = 64;
   localparam int VALUE_BITS = 32;
   localparam int CAP_W      = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [CAP_W-1:0] CAP_MIN   = 5'd2;
   localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(ENTRIES);

   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef logic [WORD_BITS-1:0] key_word_type;
   typedef key_word_type [KEY_WORDS-1:0] key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [IDX_W-1:0] rank_type;

   typedef struct packed {
      logic      func;
      key_type   key;
      value_type value;
   } req_type;

   typedef struct packed {
      logic      hit;
      value_type value_out;
      logic      evicted;
      value_type evicted_value;
      logic      duplicate;
   } rsp_type;

   typedef struct packed {
      logic [ENTRIES-1:0] valid;
      logic [ENTRIES-1:0] match;
      logic [CNT_W-1:0]   count;
   } status_type;

endpackage

[rtl/lhc_match.sv]
module lhc_match
   import lhc_pkg::*;
(
   input  key_type            key,
   input  key_type            entry_key [ENTRIES],
   input  logic [ENTRIES-1:0] valid,
   output logic [ENTRIES-1:0] match
);

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid[i] && (entry_key[i] == key);
      end
   end

endmodule

[rtl/lhc_store.sv]
module lhc_store
   import lhc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  req_type          req,
   input  logic [CNT_W-1:0] eff_cap,
   output rsp_type          rsp,
   output status_type       status
);

   logic [ENTRIES-1:0] valid_ff, valid_in;
   rank_type           rank_ff [ENTRIES];
   rank_type           rank_in [ENTRIES];
   logic [CNT_W-1:0]   count_ff, count_in;
   key_type            key_ff [ENTRIES];
   value_type          value_ff [ENTRIES];

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] old_oh;
   logic [ENTRIES-1:0] slot_oh;
   logic [ENTRIES-1:0] valid_kept;
   logic [ENTRIES-1:0] sel;
   logic               any_match;
   logic               is_lookup;
   logic               hit;
   logic               dup;
   logic               add;
   logic               evict;
   logic [CNT_W-1:0]   count_dec;
   rank_type           last_rank;
   rank_type           hit_rank;
   value_type          read_value;

   lhc_match u_match (
      .key       (req.key),
      .entry_key (key_ff),
      .valid     (valid_ff),
      .match     (match)
   );

   always_comb begin
      any_match  = |match;
      is_lookup  = (req.func == FUNC_LOOKUP);
      hit        = is_lookup && any_match;
      dup        = !is_lookup && any_match;
      add        = !is_lookup && !any_match;
      evict      = add && (count_ff >= eff_cap);
      count_dec  = count_ff - CNT_W'(1);
      last_rank  = count_dec[IDX_W-1:0];

      // ranks are distinct 0..count-1, so the LRU entry holds rank count-1
      hit_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         old_oh[i] = evict && valid_ff[i] && (rank_ff[i] == last_rank);
         if (match[i]) begin
            hit_rank = hit_rank | rank_ff[i];
         end
      end

      sel        = hit ? match : old_oh;
      read_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (sel[i]) begin
            read_value = read_value | value_ff[i];
         end
      end

      valid_kept = valid_ff & ~old_oh;
      slot_oh    = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_kept[i]) begin
            slot_oh    = '0;
            slot_oh[i] = 1'b1;
         end
      end

      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end

      if (fire && hit) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
      end else if (fire && add) begin
         valid_in = valid_kept | slot_oh;
         count_in = evict ? count_ff : count_ff + CNT_W'(1);
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_oh[i]) begin
               rank_in[i] = '0;
            end else if (valid_kept[i]) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
      end

      rsp.hit           = hit;
      rsp.value_out     = hit ? read_value : '0;
      rsp.evicted       = evict;
      rsp.evicted_value = evict ? read_value : '0;
      rsp.duplicate     = dup;

      status.valid = valid_ff;
      status.match = match;
      status.count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (fire && add && slot_oh[i]) begin
            key_ff[i]   <= req.key;
            value_ff[i] <= req.value;
         end
      end
   end

endmodule

[rtl/lru_handle_cache.sv]
// Channel   Direction  Handshake           Carries
// req       in         req_valid/req_stall  func, key words 0..3, value_in
// rsp       out        rsp_valid/rsp_stall  hit, value_out, evicted, evicted_value, duplicate
// csr       in         csr_valid/csr_ready  capacity
//
// One item per cycle while rsp_stall stays low; a request passes through the input register
// and then the result register before rsp_valid rises.
// Key compare over all 16 entries and the rank update sit between the input
// register and the result register; the stored state updates on the same edge.
// Synchronous reset empties the cache and sets capacity to 16.
// A stalled result holds the result register; the input register then holds and
// req_stall rises once it is full.
`include "lru_handle_cache_assert.svh"

module lru_handle_cache
   import lhc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [WORD_BITS-1:0] req_key_word0,
   input  logic [WORD_BITS-1:0] req_key_word1,
   input  logic [WORD_BITS-1:0] req_key_word2,
   input  logic [WORD_BITS-1:0] req_key_word3,
   input  value_type            req_value_in,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output value_type            rsp_value_out,
   output logic                 rsp_evicted,
   output value_type            rsp_evicted_value,
   output logic                 rsp_duplicate,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CAP_W-1:0]     csr_capacity
);

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] eff_cap;
   logic             in_valid_ff, in_valid_in;
   req_type          req_ff, req_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   status_type       status;
   logic             accept;
   logic             out_free;
   logic             fire;

   assign csr_ready = 1'b1;

   always_comb begin
      cap_in = (csr_valid && csr_ready) ? csr_capacity : cap_ff;
      if (cap_ff < CAP_MIN) begin
         eff_cap = CNT_W'(CAP_MIN);
      end else if (cap_ff > CAP_MAX) begin
         eff_cap = CNT_W'(CAP_MAX);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      fire      = in_valid_ff && out_free;
      req_stall = in_valid_ff && !out_free;
      accept    = req_valid && !req_stall;

      in_valid_in  = accept || (in_valid_ff && !fire);
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

      req_in.func   = req_func;
      req_in.key[0] = req_key_word0;
      req_in.key[1] = req_key_word1;
      req_in.key[2] = req_key_word2;
      req_in.key[3] = req_key_word3;
      req_in.value  = req_value_in;
   end

   lhc_store u_store (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .req     (req_ff),
      .eff_cap (eff_cap),
      .rsp     (rsp_in),
      .status  (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_ff.hit;
   assign rsp_value_out     = rsp_ff.value_out;
   assign rsp_evicted       = rsp_ff.evicted;
   assign rsp_evicted_value = rsp_ff.evicted_value;
   assign rsp_duplicate     = rsp_ff.duplicate;

   `LHC_ASSERT(a_count_tracks_valid, clock, reset, $countones(status.valid) == int'(status.count))
   `LHC_ASSERT(a_single_match, clock, reset, $onehot0(status.match))
   `LHC_ASSERT(a_fire_gives_rsp, clock, reset, fire |=> rsp_valid_ff)
   `LHC_ASSERT(a_dup_alone, clock, reset, rsp_valid_ff && rsp_ff.duplicate |-> !rsp_ff.hit && !rsp_ff.evicted)
   `LHC_ASSERT_NR(a_reset_empties, clock, reset |=> !rsp_valid_ff && !in_valid_ff)

endmodule

[bench/lru_handle_cache_checker.sv]
`timescale 1ns / 100ps

module lru_handle_cache_checker
   import lhc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_func,
   input  logic [WORD_BITS-1:0] req_key_word0,
   input  logic [WORD_BITS-1:0] req_key_word1,
   input  logic [WORD_BITS-1:0] req_key_word2,
   input  logic [WORD_BITS-1:0] req_key_word3,
   input  value_type            req_value_in,

   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_hit,
   input  value_type            rsp_value_out,
   input  logic                 rsp_evicted,
   input  value_type            rsp_evicted_value,
   input  logic                 rsp_duplicate,

   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CAP_W-1:0]     csr_capacity,

   output int                   fail_count,
   output int                   pending
);

   // shadow of the cache contents
   logic             line_valid [ENTRIES];
   key_type          line_key   [ENTRIES];
   value_type        line_value [ENTRIES];
   int               line_age   [ENTRIES];
   int               line_count;
   logic [CAP_W-1:0] cap_reg;

   rsp_type          awaited_rsp [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic check_field(string what, logic [VALUE_BITS-1:0] got,
                              logic [VALUE_BITS-1:0] want);
      if (got !== want) begin
         $display("%0t rsp %s: got %h, expected %h", $realtime, what, got, want);
         fail_count++;
      end
   endtask

   // applies one access to the shadow cache and returns the response it must give
   function automatic rsp_type access_cache(logic func, key_type key, value_type val);
      rsp_type r;
      int      found;
      int      oldest;
      int      slot;
      int      limit;
      r     = '0;
      found = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && line_valid[i] && line_key[i] == key) found = i;
      if (func == FUNC_LOOKUP) begin
         if (found >= 0) begin
            r.hit       = 1'b1;
            r.value_out = line_value[found];
            for (int i = 0; i < ENTRIES; i++)
               if (line_valid[i] && line_age[i] < line_age[found]) line_age[i]++;
            line_age[found] = 0;
         end
      end else if (found >= 0) begin
         r.duplicate = 1'b1;
      end else begin
         limit = int'((cap_reg < CAP_MIN) ? CAP_MIN : (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg);
         // only one entry leaves per add, even when capacity dropped below the count
         if (line_count >= limit) begin
            oldest = -1;
            for (int i = 0; i < ENTRIES; i++)
               if (line_valid[i] && (oldest < 0 || line_age[i] > line_age[oldest]))
                  oldest = i;
            if (oldest >= 0) begin
               r.evicted          = 1'b1;
               r.evicted_value    = line_value[oldest];
               line_valid[oldest] = 1'b0;
               line_count--;
            end
         end
         slot = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !line_valid[i]) slot = i;
         if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
               if (line_valid[i]) line_age[i]++;
            line_valid[slot] = 1'b1;
            line_key[slot]   = key;
            line_value[slot] = val;
            line_age[slot]   = 0;
            line_count++;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_age[i]   = 0;
         end
         line_count = 0;
         cap_reg    = CAP_RESET;
         awaited_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               check_field("transfer with nothing outstanding", VALUE_BITS'(1), '0);
            end else begin
               want = awaited_rsp.pop_front();
               check_field("hit", VALUE_BITS'(rsp_hit), VALUE_BITS'(want.hit));
               check_field("value_out", rsp_value_out, want.value_out);
               check_field("evicted", VALUE_BITS'(rsp_evicted), VALUE_BITS'(want.evicted));
               check_field("evicted_value", rsp_evicted_value, want.evicted_value);
               check_field("duplicate", VALUE_BITS'(rsp_duplicate),
                           VALUE_BITS'(want.duplicate));
            end
         end
         if (req_valid && !req_stall)
            awaited_rsp.push_back(access_cache(req_func,
               key_type'({req_key_word3, req_key_word2, req_key_word1, req_key_word0}),
               req_value_in));
         if (csr_valid && csr_ready) cap_reg = csr_capacity;
      end
      pending = awaited_rsp.size();
   end

endmodule

[bench/lru_handle_cache_tb.sv]
`timescale 1ns / 100ps

module lru_handle_cache_tb;
   import lhc_pkg::*;

   localparam int POOL_KEYS    = 32;
   localparam int PHASE_ITEMS  = 140;
   localparam int STALL_LIMIT  = 4000;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_func;
   logic [WORD_BITS-1:0] req_key_word0;
   logic [WORD_BITS-1:0] req_key_word1;
   logic [WORD_BITS-1:0] req_key_word2;
   logic [WORD_BITS-1:0] req_key_word3;
   value_type            req_value_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_hit;
   value_type            rsp_value_out;
   logic                 rsp_evicted;
   value_type            rsp_evicted_value;
   logic                 rsp_duplicate;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CAP_W-1:0]     csr_capacity;

   int                   fail_count;
   int                   pending;
   int                   quiet_cycles;
   bit                   idle_on = 1'b1;
   key_type              key_pool [POOL_KEYS];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   lru_handle_cache dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_key_word0     (req_key_word0),
      .req_key_word1     (req_key_word1),
      .req_key_word2     (req_key_word2),
      .req_key_word3     (req_key_word3),
      .req_value_in      (req_value_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_value_out     (rsp_value_out),
      .rsp_evicted       (rsp_evicted),
      .rsp_evicted_value (rsp_evicted_value),
      .rsp_duplicate     (rsp_duplicate),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_capacity      (csr_capacity)
   );

   lru_handle_cache_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_key_word0     (req_key_word0),
      .req_key_word1     (req_key_word1),
      .req_key_word2     (req_key_word2),
      .req_key_word3     (req_key_word3),
      .req_value_in      (req_value_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_value_out     (rsp_value_out),
      .rsp_evicted       (rsp_evicted),
      .rsp_evicted_value (rsp_evicted_value),
      .rsp_duplicate     (rsp_duplicate),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_capacity      (csr_capacity),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   function automatic key_type rand_key();
      key_type k;
      for (int w = 0; w < KEY_WORDS; w++) k[w] = {$urandom, $urandom};
      return k;
   endfunction

   function automatic value_type rand_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // some pool keys differ from a neighbor in one bit only, so each word compare matters
   function automatic key_type pool_key(int i);
      key_type k;
      if (i % 4 == 3) begin
         k = key_pool[i-1];
         k[$urandom_range(0, KEY_WORDS-1)][$urandom_range(0, WORD_BITS-1)] ^= 1'b1;
      end else begin
         k = rand_key();
      end
      return k;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(logic func, key_type key, value_type val);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_func      = func;
      req_key_word0 = key[0];
      req_key_word1 = key[1];
      req_key_word2 = key[2];
      req_key_word3 = key[3];
      req_value_in  = val;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] cap);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid    = 1'b1;
      csr_capacity = cap;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // result-side backpressure in random bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = 1'b0;
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 13) - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                   || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t no transfer for %0d cycles", $realtime, quiet_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [CAP_W-1:0] cap_plan [12];
      key_type          k;
      key_type          base;
      int               limit;
      int               psize;
      int               pick;
      cap_plan = '{5'd0, 5'd16, 5'd3, 5'd31, 5'd1, 5'd17, 5'd2, 5'd9, 5'd16, 5'd4, 5'd30,
                   5'd7};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = FUNC_ADD;
      req_key_word0 = '0;
      req_key_word1 = '0;
      req_key_word2 = '0;
      req_key_word3 = '0;
      req_value_in  = '0;
      csr_valid     = 1'b0;
      csr_capacity  = '0;
      for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = pool_key(i);
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: empty cache, extreme keys and values, duplicate, single-bit key differences
      send_item(FUNC_LOOKUP, '0, '1);
      send_item(FUNC_ADD, '1, '1);
      send_item(FUNC_ADD, '0, '0);
      send_item(FUNC_LOOKUP, '1, '0);
      send_item(FUNC_LOOKUP, '0, '1);
      send_item(FUNC_ADD, '1, 32'h0000_0005);
      base = rand_key();
      send_item(FUNC_ADD, base, $urandom);
      for (int w = 0; w < KEY_WORDS; w++) begin
         k = base;
         k[w][$urandom_range(0, WORD_BITS-1)] ^= 1'b1;
         send_item(FUNC_ADD, k, $urandom);
         send_item(FUNC_LOOKUP, k, $urandom);
      end
      send_item(FUNC_LOOKUP, base, '0);
      k    = '0;
      k[3] = '1;
      send_item(FUNC_LOOKUP, k, '0);

      for (int ph = 0; ph < 12; ph++) begin
         set_capacity(cap_plan[ph]);
         idle_on = (ph == 11) ? 1'b0 : ($urandom_range(0, 3) != 0);
         limit = int'((cap_plan[ph] < CAP_MIN) ? CAP_MIN :
                      (cap_plan[ph] > CAP_MAX) ? CAP_MAX : cap_plan[ph]);
         psize = limit + $urandom_range(1, 8);
         if (psize > POOL_KEYS) psize = POOL_KEYS;
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 44)
               send_item(FUNC_ADD, key_pool[$urandom_range(0, psize-1)], rand_value());
            else if (pick < 88)
               send_item(FUNC_LOOKUP, key_pool[$urandom_range(0, psize-1)], rand_value());
            else
               send_item(1'($urandom_range(0, 1)), rand_key(), rand_value());
         end
         for (int i = 0; i < 4; i++) begin
            pick = $urandom_range(0, POOL_KEYS-1);
            key_pool[pick] = pool_key(pick);
         end
      end

      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
